FILE: src/obb_sat_pkg.sv
// Shared constants and types for the 2D oriented-box separating-axis test.
// Used by every module of the block; depends on nothing.
package obb_sat_pkg;

  // Default coordinate width (Q12.4 at 16 bits)
  localparam int COORD_WIDTH = 16;

  // Coordinate fields carried in one input transfer
  localparam int NUM_FIELDS = 12;

  // Edge vectors tested as axes (two per box)
  localparam int NUM_EDGES = 4;

  // Result tdata width: one overlap bit padded to a byte
  localparam int OUT_TDATA_W = 8;

  // Load enables for the two stages inside a dot-product unit
  typedef struct packed {
    logic en_mul;
    logic en_sum;
  } pipe_ctl_t;

endpackage

FILE: src/obb_2d_separating_axis_test_core.sv
// Top level of the 2D oriented-box separating-axis test core.
// Depends on obb_sat_pkg, obb_sat_dot and obb_sat_axis.
//
// Each input transfer carries one box pair (center, width edge and height edge per box) and
// yields one transfer holding the overlap bit: 1 when no edge direction of either box
// separates the boxes, touching included. The core takes one pair every cycle while the
// output side does not stall and returns results in order. Its four register stages are the
// input register with the center difference, the 28 parallel coordinate multipliers, the
// dot-product add and magnitude, and the result register. Each stage holds while the
// stage after it is full and stalled, so empty stages keep taking input during output
// backpressure. All arithmetic is exact; nothing rounds or saturates.
module obb_2d_separating_axis_test_core #(
  parameter  int COORD_WIDTH = obb_sat_pkg::COORD_WIDTH,
  localparam int S_TDATA_W   = ((obb_sat_pkg::NUM_FIELDS * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                                clk,
  input  logic                                rst,
  // s_tdata, lowest bits first: left_center_x, left_center_y, left_width_edge_x,
  // left_width_edge_y, left_height_edge_x, left_height_edge_y, right_center_x,
  // right_center_y, right_width_edge_x, right_width_edge_y, right_height_edge_x,
  // right_height_edge_y (COORD_WIDTH bits each), zero pad to a byte
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [S_TDATA_W-1:0]                s_tdata,
  // m_tdata, lowest bit first: overlap, zero pad to a byte
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [obb_sat_pkg::OUT_TDATA_W-1:0] m_tdata
);

  localparam int W  = COORD_WIDTH;
  localparam int NE = obb_sat_pkg::NUM_EDGES;
  localparam int EW = 2 * W;

  // Field positions inside s_tdata
  localparam int F_LCX = 0;
  localparam int F_LCY = 1;
  localparam int F_LWX = 2;
  localparam int F_LWY = 3;
  localparam int F_LHX = 4;
  localparam int F_LHY = 5;
  localparam int F_RCX = 6;
  localparam int F_RCY = 7;
  localparam int F_RWX = 8;
  localparam int F_RWY = 9;
  localparam int F_RHX = 10;
  localparam int F_RHY = 11;

  logic                   v0;
  logic                   v1;
  logic                   v2;
  logic                   en0;
  logic                   en1;
  logic                   en2;
  logic                   en3;
  obb_sat_pkg::pipe_ctl_t dot_ctl;

  logic signed [W-1:0]    edge_x [NE];
  logic signed [W-1:0]    edge_y [NE];
  logic signed [W-1:0]    edge_x_next [NE];
  logic signed [W-1:0]    edge_y_next [NE];
  logic signed [W:0]      diff_x;
  logic signed [W:0]      diff_y;
  logic signed [W:0]      diff_x_next;
  logic signed [W:0]      diff_y_next;

  logic [EW-1:0]          edge_mag [NE][NE];
  logic [EW:0]            gap_mag  [NE];
  logic [NE-1:0]          separated;
  logic                   overlap;
  logic                   overlap_next;

  // Stage enables: a stage loads when empty or when the stage after it moves
  assign en3      = !m_tvalid || m_tready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign en0      = !v0 || en1;
  assign s_tready = en0;

  assign dot_ctl.en_mul = en1;
  assign dot_ctl.en_sum = en2;

  // Unpack edges and form the center difference at the input register
  always_comb begin
    edge_x_next[0] = s_tdata[F_LWX*W +: W];
    edge_y_next[0] = s_tdata[F_LWY*W +: W];
    edge_x_next[1] = s_tdata[F_LHX*W +: W];
    edge_y_next[1] = s_tdata[F_LHY*W +: W];
    edge_x_next[2] = s_tdata[F_RWX*W +: W];
    edge_y_next[2] = s_tdata[F_RWY*W +: W];
    edge_x_next[3] = s_tdata[F_RHX*W +: W];
    edge_y_next[3] = s_tdata[F_RHY*W +: W];
    diff_x_next = $signed({s_tdata[F_LCX*W + W - 1], s_tdata[F_LCX*W +: W]})
                - $signed({s_tdata[F_RCX*W + W - 1], s_tdata[F_RCX*W +: W]});
    diff_y_next = $signed({s_tdata[F_LCY*W + W - 1], s_tdata[F_LCY*W +: W]})
                - $signed({s_tdata[F_RCY*W + W - 1], s_tdata[F_RCY*W +: W]});
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (en0) begin
      edge_x <= edge_x_next;
      edge_y <= edge_y_next;
      diff_x <= diff_x_next;
      diff_y <= diff_y_next;
    end
  end

  // Edge-against-edge projections; the matrix is symmetric, so build the upper half only
  for (genvar i = 0; i < NE; i++) begin : g_axis_row
    for (genvar j = 0; j < NE; j++) begin : g_axis_col
      if (j >= i) begin : g_dot
        obb_sat_dot #(.AW(W), .BW(W)) u_edge_dot (
          .clk (clk),
          .ctl (dot_ctl),
          .a_x (edge_x[j]),
          .a_y (edge_y[j]),
          .b_x (edge_x[i]),
          .b_y (edge_y[i]),
          .mag (edge_mag[i][j])
        );
      end else begin : g_mirror
        assign edge_mag[i][j] = edge_mag[j][i];
      end
    end

    // Center-difference projection on this axis
    obb_sat_dot #(.AW(W + 1), .BW(W)) u_gap_dot (
      .clk (clk),
      .ctl (dot_ctl),
      .a_x (diff_x),
      .a_y (diff_y),
      .b_x (edge_x[i]),
      .b_y (edge_y[i]),
      .mag (gap_mag[i])
    );

    obb_sat_axis #(.EW(EW)) u_axis (
      .edge_mag  (edge_mag[i]),
      .gap_mag   (gap_mag[i]),
      .separated (separated[i])
    );
  end

  // Any separating axis means no overlap
  assign overlap_next = !(|separated);

  // Advance valid flags and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      v0       <= 1'b0;
      v1       <= 1'b0;
      v2       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (en0) begin
        v0 <= s_tvalid;
      end
      if (en1) begin
        v1 <= v0;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        m_tvalid <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      overlap <= overlap_next;
    end
  end

  assign m_tdata = {{(obb_sat_pkg::OUT_TDATA_W - 1){1'b0}}, overlap};

  // Any empty stage must open the input side
  a_ready_on_bubble: assert property (@(posedge clk) disable iff (rst)
    (!v0 || !v1 || !v2 || !m_tvalid) |-> s_tready)
    else $error("input stalled while the pipeline has an empty stage");

  // An input transfer with no output transfer adds exactly one item in flight
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !(m_tvalid && m_tready)) |=>
      ($countones({v0, v1, v2, m_tvalid}) == $past($countones({v0, v1, v2, m_tvalid})) + 1))
    else $error("accepted item lost or duplicated in the pipeline");

  // An output transfer with no input transfer removes exactly one item
  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (!(s_tvalid && s_tready) && m_tvalid && m_tready) |=>
      ($countones({v0, v1, v2, m_tvalid}) + 1 == $past($countones({v0, v1, v2, m_tvalid}))))
    else $error("delivered item not removed from the pipeline");

  // A full dot stage behind a stalled result keeps its pending answer
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (v2 && m_tvalid && !m_tready) |=> (v2 && $stable(overlap_next)))
    else $error("pending result changed during output stall");

endmodule

FILE: src/obb_sat_dot.sv
// One 2D dot-product unit: registered products, then registered magnitude of their sum.
// Depends on obb_sat_pkg for the stage enable struct and default widths.
module obb_sat_dot #(
  parameter int AW = obb_sat_pkg::COORD_WIDTH,
  parameter int BW = obb_sat_pkg::COORD_WIDTH
) (
  input  logic                   clk,
  input  obb_sat_pkg::pipe_ctl_t ctl,
  input  logic signed [AW-1:0]   a_x,
  input  logic signed [AW-1:0]   a_y,
  input  logic signed [BW-1:0]   b_x,
  input  logic signed [BW-1:0]   b_y,
  output logic [AW+BW-1:0]       mag
);

  localparam int PW = AW + BW;
  localparam int SW = PW + 1;

  logic signed [PW-1:0] prod_x;
  logic signed [PW-1:0] prod_y;
  logic signed [PW-1:0] prod_x_next;
  logic signed [PW-1:0] prod_y_next;
  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] sum_neg;
  logic [PW-1:0]        mag_next;

  // Multiply each coordinate pair exactly
  assign prod_x_next = a_x * b_x;
  assign prod_y_next = a_y * b_y;

  // Add the products and take the magnitude; it always fits in PW bits
  always_comb begin
    sum      = {prod_x[PW-1], prod_x} + {prod_y[PW-1], prod_y};
    sum_neg  = -sum;
    mag_next = sum[SW-1] ? sum_neg[PW-1:0] : sum[PW-1:0];
  end

  // Hold each stage unless its enable lets the next item in
  always_ff @(posedge clk) begin
    if (ctl.en_mul) begin
      prod_x <= prod_x_next;
      prod_y <= prod_y_next;
    end
    if (ctl.en_sum) begin
      mag <= mag_next;
    end
  end

endmodule

FILE: src/obb_sat_axis.sv
// Per-axis compare: sum of edge projections against twice the center projection.
// Depends on obb_sat_pkg for the edge count.
module obb_sat_axis #(
  parameter int EW = 2 * obb_sat_pkg::COORD_WIDTH
) (
  input  logic [EW-1:0] edge_mag [obb_sat_pkg::NUM_EDGES],
  input  logic [EW:0]   gap_mag,
  output logic          separated
);

  localparam int TW = EW + 2;

  logic [TW-1:0] proj_sum;
  logic [TW-1:0] gap_twice;

  // Sum the four projections; two guard bits keep it exact
  always_comb begin
    proj_sum = '0;
    for (int j = 0; j < obb_sat_pkg::NUM_EDGES; j++) begin
      proj_sum = proj_sum + {2'b00, edge_mag[j]};
    end
    gap_twice = {gap_mag, 1'b0};
    // Touching counts as overlap, so only a strict shortfall separates
    separated = proj_sum < gap_twice;
  end

endmodule

FILE: bench/tb_obb_2d_separating_axis_test_core.sv
// Self-checking bench for obb_2d_separating_axis_test_core: directed box pairs, then
// random pairs under several idle and stall mixes, each checked against a table or a local model.
// Depends on obb_sat_pkg and the core itself.
module tb_obb_2d_separating_axis_test_core;

  localparam int CW         = obb_sat_pkg::COORD_WIDTH;
  localparam int RAND_ITEMS = 210;
  localparam int CYCLE_CAP  = 400000;
  localparam int DRAIN_WAIT = 12;

  // Coordinate slots inside s_tdata, lowest first
  localparam int LCX = 0;
  localparam int LCY = 1;
  localparam int LWX = 2;
  localparam int LWY = 3;
  localparam int LHX = 4;
  localparam int LHY = 5;
  localparam int RCX = 6;
  localparam int RCY = 7;
  localparam int RWX = 8;
  localparam int RWY = 9;
  localparam int RHX = 10;
  localparam int RHY = 11;

  typedef logic [obb_sat_pkg::NUM_FIELDS-1:0][CW-1:0] pair_t;

  typedef struct packed {
    pair_t pair;
    logic  known;
    logic  want;
  } dir_row_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [$bits(pair_t)-1:0] s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [obb_sat_pkg::OUT_TDATA_W-1:0] m_tdata;

  logic     pending_overlap[$];
  dir_row_t dir_tab[$];
  int       errors;
  int       cycles;
  int       send_idle;
  int       recv_stall;

  obb_2d_separating_axis_test_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Free-running clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic longint crd(pair_t p, int k);
    return longint'($signed(p[k]));
  endfunction

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Edge axes of both boxes; a pair is apart as soon as one axis shows a gap wider than the spans
  function automatic logic boxes_overlap(pair_t p);
    longint ex[4];
    longint ey[4];
    longint dx;
    longint dy;
    longint span;
    longint gap;
    logic   hit;
    dx = crd(p, LCX) - crd(p, RCX);
    dy = crd(p, LCY) - crd(p, RCY);
    ex[0] = crd(p, LWX); ey[0] = crd(p, LWY);
    ex[1] = crd(p, LHX); ey[1] = crd(p, LHY);
    ex[2] = crd(p, RWX); ey[2] = crd(p, RWY);
    ex[3] = crd(p, RHX); ey[3] = crd(p, RHY);
    hit = 1'b1;
    for (int i = 0; i < 4; i++) begin
      span = 0;
      for (int j = 0; j < 4; j++)
        span += mag(ex[j] * ex[i] + ey[j] * ey[i]);
      gap = 2 * mag(dx * ex[i] + dy * ey[i]);
      if (span < gap)
        hit = 1'b0;
    end
    return hit;
  endfunction

  function automatic pair_t pack_pair(int lcx, int lcy, int lwx, int lwy, int lhx, int lhy,
                                      int rcx, int rcy, int rwx, int rwy, int rhx, int rhy);
    pair_t p;
    p[LCX] = lcx[CW-1:0]; p[LCY] = lcy[CW-1:0];
    p[LWX] = lwx[CW-1:0]; p[LWY] = lwy[CW-1:0];
    p[LHX] = lhx[CW-1:0]; p[LHY] = lhy[CW-1:0];
    p[RCX] = rcx[CW-1:0]; p[RCY] = rcy[CW-1:0];
    p[RWX] = rwx[CW-1:0]; p[RWY] = rwy[CW-1:0];
    p[RHX] = rhx[CW-1:0]; p[RHY] = rhy[CW-1:0];
    return p;
  endfunction

  function automatic int srand(int r);
    return int'($urandom_range(2 * r)) - r;
  endfunction

  // Full-range value with the two extremes weighted up
  function automatic int wild_coord();
    int roll;
    int v;
    roll = $urandom_range(99);
    v = $urandom;
    if (roll < 8)
      return -32768;
    else if (roll < 16)
      return 32767;
    return int'($signed(v[CW-1:0]));
  endfunction

  function automatic pair_t random_pair();
    int    kind;
    int    a;
    int    b;
    int    lx;
    int    ly;
    int    ox;
    int    oy;
    pair_t p;
    kind = $urandom_range(99);
    if (kind < 20) begin
      // Unrelated coordinates over the whole range
      for (int k = 0; k < obb_sat_pkg::NUM_FIELDS; k++)
        p[k] = CW'(wild_coord());
    end else if (kind < 55) begin
      // Small boxes near each other: a mix of hits and misses
      lx = srand(8000);
      ly = srand(8000);
      p = pack_pair(lx, ly, srand(600), srand(600), srand(600), srand(600),
                    lx + srand(1500), ly + srand(1500),
                    srand(600), srand(600), srand(600), srand(600));
    end else if (kind < 90) begin
      // Equal rectangles side by side, offset by one edge plus a nudge: touching and near misses
      a  = srand(1000);
      b  = srand(1000);
      lx = srand(20000);
      ly = srand(20000);
      if ($urandom_range(1)) begin
        ox = a;
        oy = b;
      end else begin
        ox = -b;
        oy = a;
      end
      ox += srand(1);
      oy += srand(1);
      p = pack_pair(lx, ly, a, b, -b, a, lx - ox, ly - oy, a, b, -b, a);
    end else begin
      // Zero-length edges scattered over random content
      for (int k = 0; k < obb_sat_pkg::NUM_FIELDS; k++)
        p[k] = (k != LCX && k != LCY && k != RCX && k != RCY && $urandom_range(1)) ?
               '0 : CW'(srand(3000));
    end
    return p;
  endfunction

  task automatic add_row(logic known, logic want,
                         int lcx, int lcy, int lwx, int lwy, int lhx, int lhy,
                         int rcx, int rcy, int rwx, int rwy, int rhx, int rhy);
    dir_row_t r;
    r.pair  = pack_pair(lcx, lcy, lwx, lwy, lhx, lhy, rcx, rcy, rwx, rwy, rhx, rhy);
    r.known = known;
    r.want  = want;
    dir_tab.push_back(r);
  endtask

  // Offer one pair, idling first at the current rate, and record the expected overlap
  task automatic send_pair(pair_t p, logic known, logic want);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      s_tdata  <= random_pair();
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= p;
    @(posedge clk);
    while (!s_tready)
      @(posedge clk);
    pending_overlap.push_back(known ? want : boxes_overlap(p));
  endtask

  // Hold the sender off until every result is back
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_overlap.size() != 0)
      @(posedge clk);
  endtask

  // Result side: random stall and in-order check
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      errors = 0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall);
      if (m_tvalid && m_tready) begin
        if (pending_overlap.size() == 0) begin
          $error("unexpected result transfer: overlap %0b", m_tdata[0]);
          errors++;
        end else begin
          logic exp_bit;
          exp_bit = pending_overlap.pop_front();
          if (m_tdata[0] !== exp_bit) begin
            $error("overlap: expected %0b, got %0b", exp_bit, m_tdata[0]);
            errors++;
          end
          if (m_tdata[obb_sat_pkg::OUT_TDATA_W-1:1] !== '0) begin
            $error("pad: expected 0, got %0h", m_tdata[obb_sat_pkg::OUT_TDATA_W-1:1]);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (rst) begin
      cycles <= 0;
    end else begin
      cycles <= cycles + 1;
    end
    if (cycles > CYCLE_CAP) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    send_idle  = 0;
    recv_stall = 0;

    // Directed pairs: extremes, touching, separation and zero edges
    add_row(1, 1,  0, 0, 0, 0, 0, 0,  0, 0, 0, 0, 0, 0);
    add_row(1, 1,  32767, 32767, 32767, 32767, 32767, 32767,
                   32767, 32767, 32767, 32767, 32767, 32767);
    add_row(1, 1,  -32768, -32768, -32768, -32768, -32768, -32768,
                   -32768, -32768, -32768, -32768, -32768, -32768);
    add_row(1, 0,  0, 0, 16, 0, 0, 16,  1000, 0, 16, 0, 0, 16);
    add_row(1, 1,  0, 0, 16, 0, 0, 16,  16, 0, 16, 0, 0, 16);
    add_row(1, 0,  0, 0, 16, 0, 0, 16,  17, 0, 16, 0, 0, 16);
    add_row(1, 1,  0, 0, 0, 0, 0, 16,  100, 0, 0, 0, 0, 16);
    add_row(1, 1,  32767, 32767, 0, 0, 0, 0,  -32768, -32768, 0, 0, 0, 0);
    add_row(1, 1,  0, 0, 16, 16, -16, 16,  -16, -16, 16, 16, -16, 16);
    add_row(0, 0,  0, 0, 16, 16, -16, 16,  -17, -16, 16, 16, -16, 16);
    add_row(1, 0,  -32768, 0, 1, 0, 0, 1,  32767, 0, 1, 0, 0, 1);
    add_row(0, 0,  0, 0, 0, 0, 0, 16,  1000, 1000, 16, 0, 0, 16);
    add_row(0, 0,  32767, 32767, 32767, 32767, 32767, 32767,
                   -32768, -32768, 32767, 32767, 32767, 32767);
    add_row(0, 0,  32767, 32767, -32768, 1, 1, -32768,
                   -32768, -32768, -32768, 1, 1, -32768);
    add_row(0, 0,  0, 0, -32768, 32767, 32767, -32768,
                   32767, -32768, -32768, 32767, 32767, -32768);
    add_row(0, 0,  -32768, 32767, -1, -1, 1, -1,  32767, -32768, -1, -1, 1, -1);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i])
      send_pair(dir_tab[i].pair, dir_tab[i].known, dir_tab[i].want);
    drain();

    // Random phases: free flow, sparse sender, stalling receiver, light mix of both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 86; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 86; end
        default: begin send_idle = 14; recv_stall = 14; end
      endcase
      for (int n = 0; n < RAND_ITEMS; n++)
        send_pair(random_pair(), 1'b0, 1'b0);
      drain();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0 && pending_overlap.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: obb_2d_separating_axis_test_core.f
src/obb_sat_pkg.sv
src/obb_sat_dot.sv
src/obb_sat_axis.sv
src/obb_2d_separating_axis_test_core.sv
bench/tb_obb_2d_separating_axis_test_core.sv
